@@ sv/sitoa_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Holds the shared widths, character codes and the double-dabble step.
// Has no dependencies of its own.
package sitoa_pkg;

  // Input width and the number of BCD digits needed for its magnitude.
  localparam int VALUE_W   = 32;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = DIGITS * 4;
  localparam int DD_W      = BCD_W + VALUE_W;

  // Conversion is split over this many stages, a fixed number of bits each.
  localparam int DD_STAGES = 4;
  localparam int DD_BITS   = VALUE_W / DD_STAGES;

  // Character codes.
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;

  // BCD digits in the upper part, remaining binary bits in the lower part.
  typedef logic [DD_W-1:0] dd_word_t;

  // Runs DD_BITS steps of shift-and-add-3 on the BCD/binary word.
  function automatic dd_word_t dabble_steps(input dd_word_t x_in);
    dd_word_t x;
    logic [3:0] dig;
    x = x_in;
    for (int j = 0; j < DD_BITS; j++) begin
      for (int d = 0; d < DIGITS; d++) begin
        dig = x[VALUE_W + 4*d +: 4];
        if (dig >= 4'd5) begin
          x[VALUE_W + 4*d +: 4] = dig + 4'd3;
        end
      end
      x = x << 1;
    end
    return x;
  endfunction

endpackage

@@ sv/signed_int_to_decimal_ascii_top.sv @@
// Signed 32-bit integer to decimal ASCII text, one character per request out.
// The pipeline takes a new item each cycle unless in_stall; each item passes stages 0 to LAST,
// then the serializer, before its first character shows. It gives 1 to 11 characters (digits,
// plus a minus sign if negative), one per cycle unless out_stall; the serializer sets the rate.
// Reset (rst_n, synchronous, active low) clears every valid bit; data is not reset.
// Uses sitoa_pkg for widths, character codes and the double-dabble step.
module signed_int_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);

  localparam int NSTG = sitoa_pkg::DD_STAGES + 2;
  localparam int LAST = NSTG - 1;

  // Pipeline registers: stage 0 takes the magnitude, stages 1..DD_STAGES convert,
  // the last stage normalizes the digits to the top.
  logic                     vld_r [0:LAST];
  logic                     neg_r [0:LAST];
  sitoa_pkg::dd_word_t      dd_r  [0:sitoa_pkg::DD_STAGES];
  logic [sitoa_pkg::BCD_W-1:0] nm_bcd_r;
  logic [3:0]               nm_ndig_r;
  logic                     rdy   [0:LAST];

  // Serializer registers.
  logic                     ser_vld_r;
  logic                     ser_sign_r;
  logic [3:0]               ser_rem_r;
  logic [sitoa_pkg::BCD_W-1:0] ser_bcd_r;

  logic out_fire;
  logic ser_done;
  logic ser_free;
  logic ser_take;

  // Serializer handshake.
  assign out_fire = ser_vld_r && !out_stall;
  assign ser_done = out_fire && !ser_sign_r && (ser_rem_r == 4'd1);
  assign ser_free = !ser_vld_r || ser_done;
  assign ser_take = vld_r[LAST] && ser_free;

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[LAST] = !vld_r[LAST] || ser_free;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Normalize step: count significant digits and shift them to the top.
  logic [3:0]                  nm_ndig_nxt;
  logic [3:0]                  nm_lz;
  logic [sitoa_pkg::BCD_W-1:0] nm_bcd_nxt;
  logic [sitoa_pkg::BCD_W-1:0] conv_bcd;

  assign conv_bcd = dd_r[sitoa_pkg::DD_STAGES][sitoa_pkg::DD_W-1 -: sitoa_pkg::BCD_W];

  always_comb begin
    nm_ndig_nxt = 4'd1;
    for (int i = 0; i < sitoa_pkg::DIGITS; i++) begin
      if (conv_bcd[4*i +: 4] != 4'd0) begin
        nm_ndig_nxt = 4'(i + 1);
      end
    end
    nm_lz      = 4'(sitoa_pkg::DIGITS) - nm_ndig_nxt;
    nm_bcd_nxt = conv_bcd << {nm_lz, 2'b00};
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Data of the pipeline; the magnitude is formed unsigned so the most
  // negative value converts without overflow.
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      neg_r[0] <= in_value[31];
      dd_r[0]  <= {{sitoa_pkg::BCD_W{1'b0}},
                   (in_value[31] ? (32'd0 - in_value) : in_value)};
    end
    for (int k = 1; k <= sitoa_pkg::DD_STAGES; k++) begin
      if (rdy[k] && vld_r[k-1]) begin
        neg_r[k] <= neg_r[k-1];
        dd_r[k]  <= sitoa_pkg::dabble_steps(dd_r[k-1]);
      end
    end
    if (rdy[LAST] && vld_r[LAST-1]) begin
      neg_r[LAST] <= neg_r[LAST-1];
      nm_bcd_r    <= nm_bcd_nxt;
      nm_ndig_r   <= nm_ndig_nxt;
    end
  end

  // Serializer valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
    end else if (ser_take) begin
      ser_vld_r <= 1'b1;
    end else if (ser_done) begin
      ser_vld_r <= 1'b0;
    end
  end

  // Serializer data: sign first, then digits from the top, one per request.
  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_sign_r <= neg_r[LAST];
      ser_rem_r  <= nm_ndig_r;
      ser_bcd_r  <= nm_bcd_r;
    end else if (out_fire) begin
      if (ser_sign_r) begin
        ser_sign_r <= 1'b0;
      end else begin
        ser_rem_r <= ser_rem_r - 4'd1;
        ser_bcd_r <= ser_bcd_r << 4;
      end
    end
  end

  // Output character.
  assign out_valid     = ser_vld_r;
  assign out_character = ser_sign_r ? sitoa_pkg::ASCII_MINUS
                       : (sitoa_pkg::ASCII_ZERO + {4'd0, ser_bcd_r[sitoa_pkg::BCD_W-1 -: 4]});
  assign out_last      = !ser_sign_r && (ser_rem_r == 4'd1);

  // The minus sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == sitoa_pkg::ASCII_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  // A busy serializer holds between one and ten digits.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> (ser_rem_r != 4'd0 && ser_rem_r <= 4'(sitoa_pkg::DIGITS)))
    else $error("serializer digit count out of range");

  // Every digit sent out is a decimal digit.
  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_vld_r && !ser_sign_r) |-> (ser_bcd_r[sitoa_pkg::BCD_W-1 -: 4] <= 4'd9))
    else $error("non-decimal digit at output");

endmodule

@@ sim/decimal_text_checker.sv @@
`timescale 1ns / 100ps
// Checker for the signed integer to decimal ASCII converter: predicts the text of
// every accepted request and compares each output character against it.
// Depends on sitoa_pkg for the value width and the character codes.
module decimal_text_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [sitoa_pkg::VALUE_W-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_character,
  input  logic                          out_last,
  output int                            fail_count,
  output int                            pending,
  output int                            chars_checked
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Characters still owed by the block, oldest first.
  text_char_t expected_text[$];
  int         errors = 0;
  int         checked = 0;
  int         queued = 0;

  assign fail_count    = errors;
  assign pending       = queued;
  assign chars_checked = checked;

  // Appends the decimal text of one integer: sign first, digits most significant first.
  function automatic void predict_text(input logic [sitoa_pkg::VALUE_W-1:0] value);
    logic [sitoa_pkg::VALUE_W-1:0] mag;
    logic [3:0]                    digits[$];
    text_char_t                    text[$];
    text_char_t                    ch;
    // The magnitude is taken unsigned, so the most negative value does not overflow.
    mag = value[sitoa_pkg::VALUE_W-1] ? -value : value;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[sitoa_pkg::VALUE_W-1]) begin
      ch.code = sitoa_pkg::ASCII_MINUS;
      ch.last = 1'b0;
      text.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = sitoa_pkg::ASCII_ZERO + 8'(digits[i]);
      ch.last = 1'b0;
      text.push_back(ch);
    end
    text[text.size() - 1].last = 1'b1;
    foreach (text[i]) begin
      expected_text.push_back(text[i]);
    end
  endfunction

  // Watch both channels; compare each accepted character with the oldest one owed.
  always @(posedge clk) begin : watch_channels
    text_char_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_text(in_value);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_text.size() == 0) begin
          $error("unexpected character %0d (last %0b) with nothing owed",
                 out_character, out_last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.code) begin
            $error("out_character mismatch: expected %0d, got %0d", want.code, out_character);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
      queued = expected_text.size();
    end
  end

endmodule

@@ sim/tb_signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the signed integer to decimal ASCII converter: drives requests
// under three stall mixes and gives the verdict. Depends on sitoa_pkg, the block
// and decimal_text_checker.
module tb_signed_int_to_decimal_ascii_top;

  localparam int RANDOM_PER_PHASE = 88;
  localparam int QUIET_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 20;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [sitoa_pkg::VALUE_W-1:0] in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_character;
  logic                          out_last;

  int fail_count;
  int pending;
  int chars_checked;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int values_sent = 0;
  int quiet_cycles = 0;

  signed_int_to_decimal_ascii_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  decimal_text_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random; the decision is made away from the sampling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // End the run if no request moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("signed_int_to_decimal_ascii_top verification failed");
      $finish;
    end
  end

  // Offers one request, idling first at random, and returns once it is accepted.
  task automatic send_value(input logic [sitoa_pkg::VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    values_sent++;
  endtask

  // Random integer: mostly a random digit count and sign, sometimes any 32-bit pattern.
  function automatic logic [sitoa_pkg::VALUE_W-1:0] random_value();
    int unsigned len;
    longint      lo;
    longint      hi;
    logic [sitoa_pkg::VALUE_W-1:0] mag;
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    len = $urandom_range(10, 1);
    lo = (len == 1) ? 0 : 64'd10 ** (len - 1);
    hi = (len == 10) ? 64'd2147483647 : 64'd10 ** len - 1;
    mag = $urandom_range(32'(hi), 32'(lo));
    if ($urandom_range(1) == 1) begin
      // The extra negative magnitude only exists for ten digits.
      if (len == 10 && $urandom_range(7) == 0) begin
        return 32'h8000_0000;
      end
      return -mag;
    end
    return mag;
  endfunction

  initial begin : stimulus
    logic [sitoa_pkg::VALUE_W-1:0] directed_values[] = '{
      32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd9, -32'd10, 32'd99, 32'd100,
      -32'd100, 32'd12345, -32'd67890, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000,
      32'd1000000000, -32'd1000000000, 32'd999999999, -32'd999999999, 32'd2000000000
    };
    int idle_mix[3][2] = '{'{32, 69}, '{69, 32}, '{0, 0}};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_value  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = idle_mix[phase][0];
      recv_stall_pct = idle_mix[phase][1];
      // Boundary values go first, under the first stall mix.
      if (phase == 0) begin
        foreach (directed_values[i]) begin
          send_value(directed_values[i]);
        end
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_value(random_value());
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain what is owed, then give the pipeline time to show anything stray.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (boundary values, then random signs and lengths)",
             values_sent);
    $display("into %0d checked characters under three stall mixes.", chars_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("signed_int_to_decimal_ascii_top verification clean");
    end else begin
      $display("signed_int_to_decimal_ascii_top verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/sitoa_pkg.sv
sv/signed_int_to_decimal_ascii_top.sv
sim/decimal_text_checker.sv
sim/tb_signed_int_to_decimal_ascii_top.sv
